/* rtl/stdb_pkg.sv */
`default_nettype none

package stdb_pkg;

    localparam int ID_W      = 32;
    localparam int TIME_W    = 24;
    localparam int DELTA_W   = 16;
    localparam int CNT_W     = 3;
    localparam int HIT_SLOTS = 4;
    localparam int MAX_HITS  = 4;
    localparam int HIT_LIMIT = (MAX_HITS < HIT_SLOTS) ? MAX_HITS : HIT_SLOTS;

    localparam logic [TIME_W-1:0] TIME_MAX       = '1;
    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = TIME_W'(100000);

    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_RETAIN = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic ACT_REMOVE = 1'b0;
    localparam logic ACT_APPLY  = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ID_W-1:0]    primary_id;
        logic [CNT_W-1:0]   hit_count;
        logic [ID_W-1:0]    hit_a;
        logic [ID_W-1:0]    hit_b;
        logic [ID_W-1:0]    hit_c;
        logic [ID_W-1:0]    hit_d;
        logic [DELTA_W-1:0] delta_time;
        logic               confirmed_selected;
        logic               pending_selected;
    } in_item_t;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] target_id;
        logic            last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] num;
        out_item_t  first;
        out_item_t  second;
    } push_t;

    function automatic logic id_hit(input logic [ID_W-1:0] id, input in_item_t it);
        logic [HIT_SLOTS-1:0][ID_W-1:0] slots;
        logic [CNT_W-1:0]               lim;
        logic                           hit;
        slots = {it.hit_d, it.hit_c, it.hit_b, it.hit_a};
        lim   = (it.hit_count > CNT_W'(HIT_LIMIT)) ? CNT_W'(HIT_LIMIT) : it.hit_count;
        hit   = 1'b0;
        for (int i = 0; i < HIT_SLOTS; i++)
        begin
            if ((CNT_W'(i) < lim) && (slots[i] == id))
            begin
                hit = 1'b1;
            end
        end
        return hit && (id != '0);
    endfunction

endpackage

`default_nettype wire

/* rtl/stdb_if.sv */
`default_nettype none

interface stdb_in_if import stdb_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stdb_out_if import stdb_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/stdb_fifo.sv */
`default_nettype none

module stdb_fifo import stdb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    stdb_out_if.source result
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    out_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign pop          = result.valid && result.ready;
    assign result.valid = (count_reg != '0);
    assign result.data  = mem_reg[rd_reg];
    assign room         = (count_reg <= CW'(DEPTH - 2));

    always_comb
    begin
        wr_next    = wr_reg + AW'(push.num);
        rd_next    = rd_reg + AW'(pop);
        count_next = count_reg + CW'(push.num) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> (count_reg <= CW'(DEPTH - 2)))
        else $error("result queue overflow");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.num == 2'd0) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("result queue count mismatch");

endmodule

`default_nettype wire

/* rtl/stdb_core.sv */
`default_nettype none

module stdb_core import stdb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [TIME_W-1:0] cfg_wr_data,
    input  wire logic              room,
    output push_t                  push,
    stdb_in_if.sink                item
);

    in_item_t          item_reg;
    logic              item_vld_reg, item_vld_next;
    logic [ID_W-1:0]   pending_reg, pending_next;
    logic [ID_W-1:0]   confirmed_reg, confirmed_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [TIME_W-1:0] dbt_reg;

    logic              fire;
    logic              take;
    logic              conf_hit;
    logic              pend_hit;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] sat;
    logic              rem_v;
    logic              app_v;

    assign fire       = item_vld_reg && room;
    assign item.ready = !item_vld_reg || room;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        item_vld_next  = take || (item_vld_reg && !room);
        pending_next   = pending_reg;
        confirmed_next = confirmed_reg;
        elapsed_next   = elapsed_reg;
        rem_v          = 1'b0;
        app_v          = 1'b0;
        conf_hit       = id_hit(confirmed_reg, item_reg);
        pend_hit       = id_hit(pending_reg, item_reg);
        sum            = {1'b0, elapsed_reg} + (TIME_W + 1)'(item_reg.delta_time);
        sat            = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

        unique case (item_reg.mode)
            MODE_SET:
            begin
                if (item_reg.primary_id != pending_reg)
                begin
                    pending_next = item_reg.primary_id;
                    elapsed_next = '0;
                end
            end
            MODE_RETAIN:
            begin
                if ((confirmed_reg != '0) && conf_hit)
                begin
                    if (pending_reg != confirmed_reg)
                    begin
                        pending_next = confirmed_reg;
                        elapsed_next = dbt_reg;
                    end
                end
                else if ((pending_reg != '0) && (pending_reg != confirmed_reg) && pend_hit)
                begin
                    pending_next = pending_reg;
                end
                else if (item_reg.primary_id != pending_reg)
                begin
                    pending_next = item_reg.primary_id;
                    elapsed_next = '0;
                end
            end
            MODE_TICK:
            begin
                if (pending_reg == '0)
                begin
                    if (confirmed_reg != '0)
                    begin
                        rem_v          = !item_reg.confirmed_selected;
                        confirmed_next = '0;
                    end
                end
                else if (pending_reg != confirmed_reg)
                begin
                    elapsed_next = sat;
                    if (sat >= dbt_reg)
                    begin
                        rem_v          = (confirmed_reg != '0) && !item_reg.confirmed_selected;
                        app_v          = !item_reg.pending_selected;
                        confirmed_next = pending_reg;
                    end
                end
            end
            MODE_CLEAR:
            begin
                rem_v          = (confirmed_reg != '0) && !item_reg.confirmed_selected;
                confirmed_next = '0;
                pending_next   = '0;
                elapsed_next   = '0;
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase

        push.num    = fire ? {rem_v && app_v, rem_v ^ app_v} : 2'd0;
        push.first  = rem_v ? out_item_t'{action: ACT_REMOVE, target_id: confirmed_reg,
                                          last_of_run: !app_v}
                            : out_item_t'{action: ACT_APPLY, target_id: pending_reg,
                                          last_of_run: 1'b1};
        push.second = '{action: ACT_APPLY, target_id: pending_reg, last_of_run: 1'b1};
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg  <= 1'b0;
            pending_reg   <= '0;
            confirmed_reg <= '0;
            elapsed_reg   <= '0;
            dbt_reg       <= DEBOUNCE_RESET;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            if (fire)
            begin
                pending_reg   <= pending_next;
                confirmed_reg <= confirmed_next;
                elapsed_reg   <= elapsed_next;
            end
            if (cfg_wr_en)
            begin
                dbt_reg <= cfg_wr_data;
            end
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && !room) |=> (item_vld_reg && $stable(item_reg)))
        else $error("held request lost while queue full");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_reg.mode == MODE_CLEAR) |=>
        (pending_reg == '0 && confirmed_reg == '0 && elapsed_reg == '0))
        else $error("clear left state behind");

    a_nonzero_target: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> (push.first.target_id != '0))
        else $error("result for id zero");

endmodule

`default_nettype wire

/* rtl/sticky_target_debouncer_top.sv */
// Sticky target debouncer.
// item:   request channel (valid/ready), one request per mode: set, set with
//         retention, tick, clear. Accepted when valid and ready are both high.
// result: up to two results per request (remove old id, apply new id), with
//         last_of_run marking the final one. Requests that yield nothing
//         produce no result.
// cfg_wr_en/cfg_wr_data: writes the 24-bit debounce time in microseconds;
//         write only while the block is idle.
// Throughput: with result.ready high, one request per cycle while requests
//         yield at most one result; requests that yield two results each are
//         held back, since the queue drains one result per cycle.
//         A request is held in the input register, then updates state and
//         pushes its results into a four-entry result queue, from which
//         the earliest result is taken. A request waits in the input
//         register while the queue has fewer than two free entries.
// Stall: while result.ready is low the queue fills, then item.ready drops;
//         nothing is lost or repeated.
// Reset: clears pending id, confirmed id, elapsed time and the queue; the
//         debounce time returns to 100000.
`default_nettype none

module sticky_target_debouncer_top import stdb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [TIME_W-1:0] cfg_wr_data,
    stdb_in_if.sink                item,
    stdb_out_if.source             result
);

    push_t push;
    logic  room;

    stdb_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .room        (room),
        .push        (push),
        .item        (item)
    );

    stdb_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

`default_nettype wire
